FILE: hdl/i2cms_pkg.sv
package i2cms_pkg;

   localparam int TX_DEPTH = 16;
   localparam int RX_DEPTH = 16;

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int TX_CW = $clog2(TX_DEPTH + 1);
   localparam int RX_CW = $clog2(RX_DEPTH + 1);

   localparam logic [2:0] KIND_HEADER  = 3'd0;
   localparam logic [2:0] KIND_PAYLOAD = 3'd1;
   localparam logic [2:0] KIND_WRITE   = 3'd2;
   localparam logic [2:0] KIND_READ    = 3'd3;
   localparam logic [2:0] KIND_EVENT   = 3'd4;

   localparam logic [2:0] ACT_START     = 3'd0;
   localparam logic [2:0] ACT_SEND      = 3'd1;
   localparam logic [2:0] ACT_STOP      = 3'd2;
   localparam logic [2:0] ACT_RESTART   = 3'd3;
   localparam logic [2:0] ACT_RECV      = 3'd4;
   localparam logic [2:0] ACT_ACK       = 3'd5;
   localparam logic [2:0] ACT_NACK_STOP = 3'd6;
   localparam logic [2:0] ACT_COMPLETE  = 3'd7;

   typedef enum logic [10:0] {
      PH_IDLE      = 11'b000_0000_0001,
      PH_W_SEND    = 11'b000_0000_0010,
      PH_W_DONE    = 11'b000_0000_0100,
      PH_R_ADDR_W  = 11'b000_0000_1000,
      PH_R_CMD     = 11'b000_0001_0000,
      PH_R_RESTART = 11'b000_0010_0000,
      PH_R_ADDR_R  = 11'b000_0100_0000,
      PH_R_START   = 11'b000_1000_0000,
      PH_R_ACK     = 11'b001_0000_0000,
      PH_R_NACK    = 11'b010_0000_0000,
      PH_R_DONE    = 11'b100_0000_0000
   } phase_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] slave_addr;
      logic [7:0] command_byte;
      logic [7:0] data_byte;
      logic [4:0] read_count;
      logic       tx_busy;
      logic       rx_full;
      logic [7:0] rx_byte;
   } req_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] tx_byte;
      logic       read_valid;
      logic [7:0] read_byte;
      logic [3:0] read_position;
      logic       was_read;
      logic       overflow;
   } rsp_type;

   typedef struct packed {
      logic             we0;
      logic [TX_AW-1:0] addr0;
      logic [7:0]       data0;
      logic             we1;
      logic [TX_AW-1:0] addr1;
      logic [7:0]       data1;
   } txq_wr_type;

endpackage

FILE: hdl/i2cms_txq.sv
module i2cms_txq (
   input  logic                       clock,
   input  i2cms_pkg::txq_wr_type      wr,
   input  logic [i2cms_pkg::TX_AW-1:0] rd_addr,
   output logic [7:0]                 rd_data,
   output logic [7:0]                 entry0,
   output logic [7:0]                 entry1
);

   logic [7:0] queue_ff [i2cms_pkg::TX_DEPTH];

   always_ff @(posedge clock) begin
      if (wr.we0) begin
         queue_ff[wr.addr0] <= wr.data0;
      end
      if (wr.we1) begin
         queue_ff[wr.addr1] <= wr.data1;
      end
   end

   assign rd_data = queue_ff[rd_addr];
   assign entry0  = queue_ff[0];
   assign entry1  = queue_ff[1];

endmodule

FILE: hdl/i2cms_ctrl.sv
module i2cms_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  i2cms_pkg::req_type item,
   output logic               emit,
   output i2cms_pkg::rsp_type rsp
);

   i2cms_pkg::phase_type          phase_ff, phase_in;
   logic                          is_read_ff, is_read_in;
   logic [i2cms_pkg::TX_CW-1:0]   tx_pos_ff, tx_pos_in;
   logic [i2cms_pkg::TX_CW-1:0]   tx_fill_ff, tx_fill_in;
   logic [i2cms_pkg::RX_CW-1:0]   rx_exp_ff, rx_exp_in;
   logic [i2cms_pkg::RX_CW-1:0]   rx_pos_ff, rx_pos_in;
   logic [i2cms_pkg::RX_CW-1:0]   count;
   i2cms_pkg::txq_wr_type         wr;
   logic [7:0]                    rd_data, entry0, entry1;

   i2cms_txq u_txq (
      .clock   (clock),
      .wr      (wr),
      .rd_addr (tx_pos_ff[i2cms_pkg::TX_AW-1:0]),
      .rd_data (rd_data),
      .entry0  (entry0),
      .entry1  (entry1)
   );

   always_comb begin
      phase_in   = phase_ff;
      is_read_in = is_read_ff;
      tx_pos_in  = tx_pos_ff;
      tx_fill_in = tx_fill_ff;
      rx_exp_in  = rx_exp_ff;
      rx_pos_in  = rx_pos_ff;
      emit       = 1'b0;
      rsp        = '0;
      wr         = '0;
      count      = '0;
      case (item.kind)
         i2cms_pkg::KIND_HEADER: begin
            if (tx_fill_ff < i2cms_pkg::TX_CW'(i2cms_pkg::TX_DEPTH)) begin
               wr.we0     = fire;
               wr.addr0   = tx_fill_ff[i2cms_pkg::TX_AW-1:0];
               wr.data0   = item.slave_addr;
               tx_fill_in = tx_fill_ff + 1'b1;
            end
            if (tx_fill_ff < i2cms_pkg::TX_CW'(i2cms_pkg::TX_DEPTH - 1)) begin
               wr.we1     = fire;
               wr.addr1   = i2cms_pkg::TX_AW'(tx_fill_ff + 1'b1);
               wr.data1   = item.command_byte;
               tx_fill_in = tx_fill_ff + 2'd2;
            end else begin
               emit         = 1'b1;
               rsp.action   = i2cms_pkg::ACT_START;
               rsp.overflow = 1'b1;
            end
         end
         i2cms_pkg::KIND_PAYLOAD: begin
            if (tx_fill_ff < i2cms_pkg::TX_CW'(i2cms_pkg::TX_DEPTH)) begin
               wr.we0     = fire;
               wr.addr0   = tx_fill_ff[i2cms_pkg::TX_AW-1:0];
               wr.data0   = item.data_byte;
               tx_fill_in = tx_fill_ff + 1'b1;
            end else begin
               emit         = 1'b1;
               rsp.action   = i2cms_pkg::ACT_START;
               rsp.overflow = 1'b1;
            end
         end
         i2cms_pkg::KIND_WRITE: begin
            if (phase_ff == i2cms_pkg::PH_IDLE) begin
               is_read_in = 1'b0;
               tx_pos_in  = '0;
               phase_in   = i2cms_pkg::PH_W_SEND;
               emit       = 1'b1;
               rsp.action = i2cms_pkg::ACT_START;
            end
         end
         i2cms_pkg::KIND_READ: begin
            if (item.read_count == 5'd0) begin
               count = i2cms_pkg::RX_CW'(1);
            end else if (32'(item.read_count) > i2cms_pkg::RX_DEPTH) begin
               count = i2cms_pkg::RX_CW'(i2cms_pkg::RX_DEPTH);
            end else begin
               count = i2cms_pkg::RX_CW'(item.read_count);
            end
            if (phase_ff == i2cms_pkg::PH_IDLE) begin
               is_read_in = 1'b1;
               rx_exp_in  = count;
               rx_pos_in  = '0;
               phase_in   = i2cms_pkg::PH_R_ADDR_W;
               emit       = 1'b1;
               rsp.action = i2cms_pkg::ACT_START;
            end
         end
         i2cms_pkg::KIND_EVENT: begin
            unique case (phase_ff)
               i2cms_pkg::PH_W_SEND: begin
                  if (!item.tx_busy) begin
                     emit = 1'b1;
                     if (tx_pos_ff < tx_fill_ff) begin
                        rsp.action  = i2cms_pkg::ACT_SEND;
                        rsp.tx_byte = rd_data;
                        tx_pos_in   = tx_pos_ff + 1'b1;
                     end else begin
                        rsp.action = i2cms_pkg::ACT_STOP;
                        phase_in   = i2cms_pkg::PH_W_DONE;
                     end
                  end
               end
               i2cms_pkg::PH_W_DONE: begin
                  tx_pos_in  = '0;
                  tx_fill_in = '0;
                  phase_in   = i2cms_pkg::PH_IDLE;
                  emit       = 1'b1;
                  rsp.action = i2cms_pkg::ACT_COMPLETE;
               end
               i2cms_pkg::PH_R_ADDR_W: begin
                  phase_in    = i2cms_pkg::PH_R_CMD;
                  emit        = 1'b1;
                  rsp.action  = i2cms_pkg::ACT_SEND;
                  rsp.tx_byte = entry0;
               end
               i2cms_pkg::PH_R_CMD: begin
                  phase_in    = i2cms_pkg::PH_R_RESTART;
                  emit        = 1'b1;
                  rsp.action  = i2cms_pkg::ACT_SEND;
                  rsp.tx_byte = entry1;
               end
               i2cms_pkg::PH_R_RESTART: begin
                  phase_in   = i2cms_pkg::PH_R_ADDR_R;
                  emit       = 1'b1;
                  rsp.action = i2cms_pkg::ACT_RESTART;
               end
               i2cms_pkg::PH_R_ADDR_R: begin
                  phase_in    = i2cms_pkg::PH_R_START;
                  emit        = 1'b1;
                  rsp.action  = i2cms_pkg::ACT_SEND;
                  rsp.tx_byte = {entry0[7:1], 1'b1};
               end
               i2cms_pkg::PH_R_START: begin
                  if (({1'b0, rx_pos_ff} + 1'b1) < {1'b0, rx_exp_ff}) begin
                     phase_in = i2cms_pkg::PH_R_ACK;
                  end else begin
                     phase_in = i2cms_pkg::PH_R_NACK;
                  end
                  emit       = 1'b1;
                  rsp.action = i2cms_pkg::ACT_RECV;
               end
               i2cms_pkg::PH_R_ACK: begin
                  if (item.rx_full) begin
                     emit              = 1'b1;
                     rsp.action        = i2cms_pkg::ACT_ACK;
                     rsp.read_valid    = 1'b1;
                     rsp.read_byte     = item.rx_byte;
                     rsp.read_position = 4'(rx_pos_ff);
                     rx_pos_in         = rx_pos_ff + 1'b1;
                     phase_in          = i2cms_pkg::PH_R_START;
                  end
               end
               i2cms_pkg::PH_R_NACK: begin
                  if (item.rx_full) begin
                     emit              = 1'b1;
                     rsp.action        = i2cms_pkg::ACT_NACK_STOP;
                     rsp.read_valid    = 1'b1;
                     rsp.read_byte     = item.rx_byte;
                     rsp.read_position = 4'(rx_pos_ff);
                     tx_pos_in         = '0;
                     tx_fill_in        = '0;
                     rx_pos_in         = '0;
                     rx_exp_in         = '0;
                     phase_in          = i2cms_pkg::PH_R_DONE;
                  end
               end
               i2cms_pkg::PH_R_DONE: begin
                  phase_in     = i2cms_pkg::PH_IDLE;
                  emit         = 1'b1;
                  rsp.action   = i2cms_pkg::ACT_COMPLETE;
                  rsp.was_read = is_read_ff;
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= i2cms_pkg::PH_IDLE;
         is_read_ff <= 1'b0;
         tx_pos_ff  <= '0;
         tx_fill_ff <= '0;
         rx_exp_ff  <= '0;
         rx_pos_ff  <= '0;
      end else if (fire) begin
         phase_ff   <= phase_in;
         is_read_ff <= is_read_in;
         tx_pos_ff  <= tx_pos_in;
         tx_fill_ff <= tx_fill_in;
         rx_exp_ff  <= rx_exp_in;
         rx_pos_ff  <= rx_pos_in;
      end
   end

endmodule

FILE: hdl/i2c_master_register_sequencer_unit.sv
// I2C master transaction sequencer. Requests and bus events enter through a
// one-entry input register; the sequencer decides on each one combinationally
// against its phase, counters and a 16-byte write queue, and any resulting
// action is held in a result register until the consumer takes it. One item is
// taken every cycle while the result side keeps up; each result passes from the
// input register into the result register. A queue request that finds too
// little room in the queue returns an overflow result; starts outside the
// idle phase are dropped silently.
module i2c_master_register_sequencer_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_kind,
   input  logic [7:0] req_slave_addr,
   input  logic [7:0] req_command_byte,
   input  logic [7:0] req_data_byte,
   input  logic [4:0] req_read_count,
   input  logic       req_tx_busy,
   input  logic       req_rx_full,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [2:0] rsp_action,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_read_valid,
   output logic [7:0] rsp_read_byte,
   output logic [3:0] rsp_read_position,
   output logic       rsp_was_read,
   output logic       rsp_overflow
);

   i2cms_pkg::req_type in_ff;
   logic               in_valid_ff, in_valid_in;
   i2cms_pkg::rsp_type out_ff;
   logic               out_valid_ff, out_valid_in;
   logic               advance;
   logic               req_accept;
   logic               emit;
   i2cms_pkg::rsp_type rsp;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   i2cms_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .fire  (advance),
      .item  (in_ff),
      .emit  (emit),
      .rsp   (rsp)
   );

   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      out_valid_in = advance ? emit : (out_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_ff <= '{kind: req_kind, slave_addr: req_slave_addr,
                    command_byte: req_command_byte, data_byte: req_data_byte,
                    read_count: req_read_count, tx_busy: req_tx_busy,
                    rx_full: req_rx_full, rx_byte: req_rx_byte};
      end
      if (advance && emit) begin
         out_ff <= rsp;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_action        = out_ff.action;
   assign rsp_tx_byte       = out_ff.tx_byte;
   assign rsp_read_valid    = out_ff.read_valid;
   assign rsp_read_byte     = out_ff.read_byte;
   assign rsp_read_position = out_ff.read_position;
   assign rsp_was_read      = out_ff.was_read;
   assign rsp_overflow      = out_ff.overflow;

   a_read_valid_action: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_read_valid == ((rsp_action == i2cms_pkg::ACT_ACK) ||
                                        (rsp_action == i2cms_pkg::ACT_NACK_STOP))))
      else $error("read_valid does not match a receive action");

   a_overflow_form: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_overflow) |->
         ((rsp_action == i2cms_pkg::ACT_START) && (rsp_tx_byte == 8'd0) &&
          !rsp_read_valid && !rsp_was_read))
      else $error("overflow result carries other fields");

   a_was_read_complete: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_was_read) |-> (rsp_action == i2cms_pkg::ACT_COMPLETE))
      else $error("was_read set outside completion");

   a_input_held: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted transfer lost from the input register");

endmodule
